// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HKV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkv assertion failed");
`define HKV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkv assertion failed");
`else
`define HKV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HKV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/hkv_pkg.sv =====
// ----------------------------------------------------------------------------
// hkv_pkg
// types, codes and hash functions of the hashed key/value table
// ----------------------------------------------------------------------------
package hkv_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCAN_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_W  = 7;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 32;

  // queue pointers wrap naturally, so the depth stays a power of two
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int ABSORB_SHL = 10;
  localparam int ABSORB_SHR = 6;
  localparam int FINISH_SHL_A = 3;
  localparam int FINISH_SHR = 11;
  localparam int FINISH_SHL_B = 15;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;

  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED = 3'd0;
  localparam status_t ST_UPDATED  = 3'd1;
  localparam status_t ST_FOUND    = 3'd2;
  localparam status_t ST_NOTFOUND = 3'd3;
  localparam status_t ST_DELETED  = 3'd4;
  localparam status_t ST_FULL     = 3'd5;

  typedef struct packed {
    mode_t              mode;
    logic [VAL_W-1:0]   value;
    logic [HASH_W-1:0]  acc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [HASH_W-1:0] absorb_byte(input logic [HASH_W-1:0] h_in,
                                                     input logic [7:0] b);
    logic [HASH_W-1:0] h;
    h = h_in + {{(HASH_W-8){1'b0}}, b};
    h = h + (h << ABSORB_SHL);
    h = h ^ (h >> ABSORB_SHR);
    return h;
  endfunction

  function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in + (h_in << FINISH_SHL_A);
    h = h ^ (h >> FINISH_SHR);
    h = h + (h << FINISH_SHL_B);
    return h;
  endfunction

endpackage

// ===== hw/rtl/hkv_in_if.sv =====
// ----------------------------------------------------------------------------
// hkv_in_if
// input channel: one key byte per transaction with mode and value
// ----------------------------------------------------------------------------
interface hkv_in_if import hkv_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  logic [7:0]        key_byte;
  logic              byte_valid;
  logic              last_byte;
  logic [VAL_W-1:0]  value_in;

  modport source (output valid, mode, key_byte, byte_valid, last_byte, value_in,
                  input ready);
  modport sink   (input valid, mode, key_byte, byte_valid, last_byte, value_in,
                  output ready);
endinterface

// ===== hw/rtl/hkv_out_if.sv =====
// ----------------------------------------------------------------------------
// hkv_out_if
// result channel: one transaction per finished key operation
// ----------------------------------------------------------------------------
interface hkv_out_if import hkv_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  value_out;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, key_hash, value_out, entry_count,
                  input ready);
  modport sink   (input valid, status, key_hash, value_out, entry_count,
                  output ready);
endinterface

// ===== hw/rtl/hkv_ram.sv =====
// ----------------------------------------------------------------------------
// hkv_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/hkv_front.sv =====
// ----------------------------------------------------------------------------
// hkv_front
// folds key bytes into the running hash and queues a command per key
// ----------------------------------------------------------------------------
module hkv_front import hkv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  hkv_in_if.sink  in_if,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    push_cmd
);

  logic [HASH_W-1:0] acc_r, acc_nxt, acc_abs;
  logic              accept;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign acc_abs     = in_if.byte_valid ? absorb_byte(acc_r, in_if.key_byte) : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = in_if.last_byte ? '0 : acc_abs;
    end
  end

  assign push           = accept && in_if.last_byte;
  assign push_cmd.mode  = in_if.mode;
  assign push_cmd.value = in_if.value_in;
  assign push_cmd.acc   = acc_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== hw/rtl/hkv_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// hkv_cmd_fifo
// short command queue between the hashing front and the table back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkv_cmd_fifo import hkv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_cmd      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `HKV_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_stat.full || pop)
  `HKV_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !q_stat.empty)

endmodule

// ===== hw/rtl/hkv_back.sv =====
// ----------------------------------------------------------------------------
// hkv_back
// walks the table for a match and a free slot, then applies the operation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkv_back import hkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      pop_cmd,
  output logic      pop,
  hkv_out_if.source out_if
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_DONE} state_t;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_ENTRIES);

  state_t                   state_r, state_nxt;
  logic [HASH_W-1:0]        key_r, key_nxt;
  mode_t                    mode_r, mode_nxt;
  logic [VAL_W-1:0]         val_r, val_nxt;
  logic [SCAN_W-1:0]        idx_r, idx_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     hit_r, hit_nxt, free_r, free_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  status_t                  status_r, status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [HASH_W-1:0]        out_hash_r, out_hash_nxt;
  logic [VAL_W-1:0]         out_value_r, out_value_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;

  logic              key_re, key_we, val_we, val_re;
  logic [IDX_W-1:0]  val_waddr;
  logic [HASH_W-1:0] key_rdata;
  logic [VAL_W-1:0]  val_rdata;
  logic              cmp_hit, cmp_free, scan_end;
  logic              is_ins, is_del, upd_fire, ins_fire, del_fire, exec;

  hkv_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_idx_r),
    .wdata (key_r),
    .re    (key_re),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  hkv_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .re    (val_re),
    .raddr (hit_idx_r),
    .rdata (val_rdata)
  );

  assign pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign key_re   = (state_r == S_SCAN) && (idx_r < SCAN_END) && !scan_end;
  // compare the entry whose key came back from the ram this cycle
  assign cmp_hit  = rd_pend_r && valid_r[rd_idx_r] && (key_rdata == key_r);
  assign cmp_free = rd_pend_r && !valid_r[rd_idx_r];
  assign scan_end = cmp_hit || (rd_pend_r && (rd_idx_r == LAST_IDX));

  assign exec     = (state_r == S_EXEC);
  assign is_ins   = (mode_r == MODE_INSERT);
  assign is_del   = (mode_r == MODE_DELETE);
  assign upd_fire = exec && is_ins && hit_r;
  assign ins_fire = exec && is_ins && !hit_r && free_r;
  assign del_fire = exec && is_del && hit_r;
  assign key_we   = ins_fire;
  assign val_we   = upd_fire || ins_fire;
  assign val_waddr = hit_r ? hit_idx_r : free_idx_r;
  assign val_re   = exec && !is_ins && !is_del && hit_r;

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    mode_nxt     = mode_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    rd_pend_nxt  = rd_pend_r;
    rd_idx_nxt   = rd_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    status_nxt   = status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_hash_nxt   = out_hash_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (pop) begin
          key_nxt     = finish_hash(pop_cmd.acc);
          mode_nxt    = pop_cmd.mode;
          val_nxt     = pop_cmd.value;
          idx_nxt     = '0;
          rd_pend_nxt = 1'b0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_pend_nxt = key_re;
        rd_idx_nxt  = idx_r[IDX_W-1:0];
        if (key_re) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (cmp_hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = rd_idx_r;
        end
        if (cmp_free && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = rd_idx_r;
        end
        if (scan_end) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (ins_fire) begin
          valid_nxt[free_idx_r] = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        if (del_fire) begin
          valid_nxt[hit_idx_r] = 1'b0;
          count_nxt = count_r - 1'b1;
        end
        if (is_ins) begin
          status_nxt = hit_r ? ST_UPDATED : (free_r ? ST_INSERTED : ST_FULL);
        end else if (is_del) begin
          status_nxt = hit_r ? ST_DELETED : ST_NOTFOUND;
        end else begin
          status_nxt = hit_r ? ST_FOUND : ST_NOTFOUND;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_hash_nxt   = key_r;
          out_value_nxt  = (status_r == ST_FOUND) ? val_rdata : '0;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_hash_r   <= out_hash_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.key_hash    = out_hash_r;
  assign out_if.value_out   = out_value_r;
  assign out_if.entry_count = out_count_r;

  `HKV_ASSERT_IMP(a_count_matches, clk, rst_n, 1'b1, count_r == CNT_W'($countones(valid_r)))
  `HKV_ASSERT_IMP(a_insert_free_slot, clk, rst_n, ins_fire, !valid_r[free_idx_r])
  `HKV_ASSERT_IMP(a_delete_valid_slot, clk, rst_n, del_fire, valid_r[hit_idx_r])
  `HKV_ASSERT_NXT(a_pop_starts_scan, clk, rst_n, pop, state_r == S_SCAN)

endmodule

// ===== hw/rtl/hashed_key_value_table_core.sv =====
// input: key bytes are taken one per cycle while the command queue is not full; a key's result
// follows its last byte once the table walk stops at a match or at the last entry.
// throughput: one key operation per table walk, set by the single key ram read port
// that is read one entry a cycle; a two-deep command queue lets bytes keep arriving.
// reset: synchronous active low; clears the hash, valid marks, entry count and queue.
// ----------------------------------------------------------------------------
// hashed_key_value_table_core
// one-at-a-time hashed key/value table with insert, delete and search
// ----------------------------------------------------------------------------
module hashed_key_value_table_core import hkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hkv_in_if.sink    in_if,
  hkv_out_if.source out_if
);

  q_stat_t q_stat;
  logic    push, pop;
  cmd_t    push_cmd, pop_cmd;

  hkv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hkv_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  hkv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_cmd (pop_cmd),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

// ===== sim/hkv_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkv_result_checker
// watches both channels of the hashed key/value table, keeps its own copy of
// the hash accumulator and the table, and compares every result transaction
// ----------------------------------------------------------------------------
module hkv_result_checker import hkv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hkv_in_if          in_mon,
  hkv_out_if         out_mon,
  output int         fail_count,
  output int         results_checked,
  output int         pending,
  output logic [7:0] status_seen
);

  typedef struct packed {
    status_t           status;
    logic [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0]  value_out;
    logic [CNT_W-1:0]  entry_count;
  } table_result_t;

  table_result_t     expected_results[$];
  logic [HASH_W-1:0] hash_acc;
  logic [HASH_W-1:0] slot_key [TABLE_ENTRIES];
  logic [VAL_W-1:0]  slot_val [TABLE_ENTRIES];
  logic              slot_used [TABLE_ENTRIES];
  logic [CNT_W-1:0]  used_count;
  int                mismatches;
  int                checked;
  logic [7:0]        seen;

  function automatic logic [31:0] fold_key_byte(input logic [31:0] acc, input logic [7:0] kb);
    logic [31:0] h;
    h = acc + {24'h0, kb};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  function automatic logic [31:0] finalize_key(input logic [31:0] acc);
    logic [31:0] h;
    h = acc + (acc << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // applies one input transaction to the table copy; returns 1 when it ends a key
  function automatic bit predict_table_op(input mode_t op, input logic [7:0] kb,
                                          input logic bv, input logic lb,
                                          input logic [VAL_W-1:0] v,
                                          output table_result_t res);
    logic [HASH_W-1:0] key;
    int hit;
    int slot;
    res = '0;
    if (bv) hash_acc = fold_key_byte(hash_acc, kb);
    if (!lb) return 1'b0;
    key = finalize_key(hash_acc);
    hash_acc = '0;
    hit = -1;
    slot = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) hit = i;
      if (!slot_used[i]) slot = i;
    end
    if (op == MODE_INSERT) begin
      if (hit >= 0) begin
        slot_val[hit] = v;
        res.status = ST_UPDATED;
      end else if (slot >= 0) begin
        slot_key[slot] = key;
        slot_val[slot] = v;
        slot_used[slot] = 1'b1;
        used_count = used_count + 1'b1;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
      end
    end else if (op == MODE_DELETE) begin
      if (hit >= 0) begin
        slot_used[hit] = 1'b0;
        used_count = used_count - 1'b1;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOTFOUND;
      end
    end else begin
      // search, and the spare mode code behaves the same way
      if (hit >= 0) begin
        res.value_out = slot_val[hit];
        res.status = ST_FOUND;
      end else begin
        res.status = ST_NOTFOUND;
      end
    end
    res.key_hash = key;
    res.entry_count = used_count;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    table_result_t exp_res;
    table_result_t got_res;
    if (!rst_n) begin
      hash_acc = '0;
      used_count = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      expected_results.delete();
      mismatches = 0;
      checked = 0;
      seen = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got_res = '{out_mon.status, out_mon.key_hash, out_mon.value_out, out_mon.entry_count};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d hash %h value %h count %0d",
                     got_res.status, got_res.key_hash, got_res.value_out,
                     got_res.entry_count);
        end else begin
          exp_res = expected_results.pop_front();
          checked++;
          seen[exp_res.status] = 1'b1;
          if (got_res !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d hash %h value %h count %0d, got status %0d hash %h value %h count %0d",
                       exp_res.status, exp_res.key_hash, exp_res.value_out,
                       exp_res.entry_count, got_res.status, got_res.key_hash,
                       got_res.value_out, got_res.entry_count);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (predict_table_op(in_mon.mode, in_mon.key_byte, in_mon.byte_valid,
                             in_mon.last_byte, in_mon.value_in, exp_res))
          expected_results.push_back(exp_res);
      end
    end
    fail_count <= mismatches;
    results_checked <= checked;
    pending <= expected_results.size();
    status_seen <= seen;
  end

endmodule

// ===== sim/tb_hashed_key_value_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_table_core
// drives key names byte by byte into the hashed key/value table with random
// gaps and result stalls; directed corner keys first, then fill, mixed and
// drain phases over a pool of names; the checker judges every result
// ----------------------------------------------------------------------------
module tb_hashed_key_value_table_core;
  import hkv_pkg::*;

  localparam mode_t MODE_SEARCH = 2'd2;
  localparam mode_t MODE_SPARE  = 2'd3;
  localparam int    POOL_SIZE   = 72;
  localparam int    STALL_LIMIT = 2000;
  localparam int    TAIL_CYCLES = 80;

  typedef logic [3:0][7:0] name_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on;
  bit   noise_on;
  int   items_sent;
  int   keys_sent;
  int   stuck;
  int   fail_count;
  int   results_checked;
  int   pending;
  logic [7:0] status_seen;

  name_t pool_name [POOL_SIZE];
  int    pool_len  [POOL_SIZE];

  hkv_in_if  in_bus ();
  hkv_out_if out_bus ();

  hashed_key_value_table_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  hkv_result_checker result_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_bus),
    .out_mon         (out_bus),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .pending         (pending),
    .status_seen     (status_seen)
  );

  always #5 clk = ~clk;

  // result side back-pressure in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stuck = 0;
      else stuck++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic drive_item(input mode_t m, input logic [7:0] kb, input logic bv,
                            input logic lb, input logic [VAL_W-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= m;
    in_bus.key_byte   <= kb;
    in_bus.byte_valid <= bv;
    in_bus.last_byte  <= lb;
    in_bus.value_in   <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (bv || lb) items_sent++;
  endtask

  // mode and value only matter on the closing transaction, so earlier bytes carry junk
  task automatic send_key(input mode_t op, input name_t nm, input int len,
                          input logic [VAL_W-1:0] v, input bit split_end);
    for (int k = 0; k < len; k++) begin
      if (noise_on && $urandom_range(0, 19) == 0)
        drive_item(mode_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, 1'b0, $urandom);
      if (k == len - 1 && !split_end)
        drive_item(op, nm[k], 1'b1, 1'b1, v);
      else
        drive_item(mode_t'($urandom_range(0, 3)), nm[k], 1'b1, 1'b0, $urandom);
    end
    if (len == 0 || split_end)
      drive_item(op, 8'($urandom), 1'b0, 1'b1, v);
    keys_sent++;
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_pool_or_fresh(input mode_t op);
    int idx;
    int len;
    name_t nm;
    if ($urandom_range(0, 99) < 85) begin
      idx = $urandom_range(0, POOL_SIZE - 1);
      nm = pool_name[idx];
      len = pool_len[idx];
    end else begin
      nm = {$urandom};
      len = $urandom_range(0, 4);
    end
    send_key(op, nm, len, $urandom, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [7:0] salt;
    int r;
    mode_t op;
    rst_n = 1'b0;
    idle_on = 1'b0;
    noise_on = 1'b0;
    items_sent = 0;
    keys_sent = 0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_INSERT;
    in_bus.key_byte = '0;
    in_bus.byte_valid = 1'b0;
    in_bus.last_byte = 1'b0;
    in_bus.value_in = '0;
    // distinct first bytes keep every pool name distinct
    salt = 8'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_name[i] = {24'($urandom), 8'(i) ^ salt};
      pool_len[i] = $urandom_range(1, 2);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_key(MODE_SEARCH, '0, 0, $urandom, 1'b0);
    send_key(MODE_INSERT, '0, 0, 32'hFFFF_FFFF, 1'b0);
    // a lone zero byte folds to zero, so it hits the empty-name key
    send_key(MODE_SEARCH, '0, 1, '0, 1'b0);
    send_key(MODE_INSERT, {24'h0, 8'hFF}, 1, 32'h0, 1'b0);
    send_key(MODE_INSERT, {24'h0, 8'hFF}, 1, 32'h5A5A_A5A5, 1'b0);
    send_key(MODE_SPARE, {24'h0, 8'hFF}, 1, $urandom, 1'b0);
    // two-byte key with an idle transaction in the middle
    drive_item(MODE_DELETE, 8'h12, 1'b1, 1'b0, $urandom);
    drive_item(MODE_SPARE, 8'hC3, 1'b0, 1'b0, $urandom);
    drive_item(MODE_INSERT, 8'h34, 1'b1, 1'b1, 32'h8000_0001);
    send_key(MODE_SEARCH, {16'h0, 8'hAB, 8'hCD}, 2, $urandom, 1'b1);
    send_key(MODE_DELETE, {24'h0, 8'h77}, 1, $urandom, 1'b0);
    send_key(MODE_DELETE, '0, 0, $urandom, 1'b0);
    send_key(MODE_DELETE, '0, 0, $urandom, 1'b0);
    send_key(MODE_SEARCH, {16'h0, 8'h34, 8'h12}, 2, $urandom, 1'b1);
    send_key(MODE_INSERT, 32'h8040_2001, 4, 32'h7FFF_FFFF, 1'b0);
    wait_drained();

    // fill: insert every pool name, enough to run out of free slots
    idle_on = 1'b1;
    noise_on = 1'b1;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if ($urandom_range(0, 7) == 0) send_pool_or_fresh(MODE_SEARCH);
      send_key(MODE_INSERT, pool_name[i], pool_len[i], $urandom, $urandom_range(0, 4) == 0);
    end
    wait_drained();

    // mixed traffic over the full table
    while (items_sent < 400) begin
      r = $urandom_range(0, 9);
      if (r < 4) op = MODE_INSERT;
      else if (r < 7) op = MODE_DELETE;
      else if (r < 9) op = MODE_SEARCH;
      else op = MODE_SPARE;
      send_pool_or_fresh(op);
    end
    wait_drained();

    // drain: mostly deletes, last stretch without any idling
    while (items_sent < 550) begin
      if (items_sent >= 470) idle_on = 1'b0;
      r = $urandom_range(0, 9);
      if (r < 6) op = MODE_DELETE;
      else if (r < 9) op = MODE_SEARCH;
      else op = MODE_INSERT;
      send_pool_or_fresh(op);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transactions over %0d keys, %0d results checked",
             items_sent, keys_sent, results_checked);
    $display("status codes seen (one bit per code, table full is bit 5): %b", status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("status: fail");
    end
    $finish;
  end

endmodule
